/* rtl/ufr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_pkg
// Types, codes and the byte-wide CRC32 step for the upload frame receiver.
// ----------------------------------------------------------------------------
package ufr_pkg;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] MAGIC_CMD = 32'h434D4E44;
   localparam logic [31:0] MAGIC_UPL = 32'h45505542;

   typedef enum logic [3:0] {
      K_PASS       = 4'd0,
      K_NAME       = 4'd1,
      K_PAYLOAD    = 4'd2,
      K_ACK        = 4'd3,
      K_READY      = 4'd4,
      K_OK         = 4'd5,
      K_ERR_CREATE = 4'd6,
      K_ERR_IO     = 4'd7,
      K_ERR_CRC    = 4'd8,
      K_UNSUP      = 4'd9,
      K_DROPPED    = 4'd10,
      K_HANDOFF    = 4'd11
   } kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] byte_value;
      logic       sink_error;
   } req_type_t_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_item_type;

   // One result transaction carries up to two items.
   typedef struct packed {
      logic         two;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return ~c;
   endfunction

endpackage

/* rtl/upload_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upload_frame_receiver_top
// Frame hunter and upload parser with per-chunk ACK and CRC32 check.
// ----------------------------------------------------------------------------
// channel  ports      dir  content
// req      req_*      in   type, byte, sink error
// rsp      rsp_*      out  kind, byte, last
// csr      csr_* apb  in   chunk_size @0x0, max_name_len @0x4
//
// One input transaction per cycle while req_stall is low; parse and CRC32 step
// are combinational into a two-entry result queue; two results from one input
// leave as two rsp items. Synchronous reset clears parse state and the queue
// and presets the CSRs. req_stall rises only while the result queue is full.
// ----------------------------------------------------------------------------
module upload_frame_receiver_top import ufr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type_t_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_item_type   rsp_data,
   input  logic           csr_psel,
   input  logic           csr_penable,
   input  logic           csr_pwrite,
   input  logic [2:0]     csr_paddr,
   input  logic [31:0]    csr_pwdata,
   output logic [31:0]    csr_prdata,
   output logic           csr_pready
);
   typedef enum logic [2:0] {
      PH_HUNT, PH_OPCODE, PH_NLEN, PH_NAME, PH_PLEN, PH_PAYLOAD, PH_CRC
   } phase_type;

   logic [15:0] chunk_ff, maxn_ff;
   logic [31:0] win_ff, win_in;
   logic [2:0]  fill_ff, fill_in;
   phase_type   ph_ff, ph_in;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] nrem_ff, nrem_in;
   logic [31:0] prem_ff, prem_in;
   logic [15:0] cfill_ff, cfill_in;
   logic [31:0] crc_ff, crc_in, exp_ff, exp_in;
   logic        wf_ff, wf_in;

   logic         room, acc, push;
   rsp_pair_type pair;
   logic [3:0]   k0, k1;
   logic [7:0]   b0;
   logic [1:0]   n;
   logic [7:0]   b;
   logic [15:0]  nlen;
   logic [31:0]  acc32, prem_dec;
   logic [16:0]  eff, fill_nx;
   logic         wf_nx;

   assign csr_pready = 1'b1;
   assign req_stall  = !room;
   assign acc        = req_valid && room;
   assign b          = req_data.byte_value;
   assign csr_prdata = csr_paddr[2] ? {16'd0, maxn_ff} : {16'd0, chunk_ff};

   always_comb begin
      win_in = win_ff; fill_in = fill_ff; ph_in = ph_ff; idx_in = idx_ff;
      nrem_in = nrem_ff; prem_in = prem_ff; cfill_in = cfill_ff;
      crc_in = crc_ff; exp_in = exp_ff; wf_in = wf_ff;
      n = 2'd0; k0 = K_PASS; k1 = K_PASS; b0 = 8'd0;
      nlen = {b, nrem_ff[7:0]};
      acc32 = 32'd0; prem_dec = prem_ff - 32'd1;
      eff = (chunk_ff == 16'd0) ? 17'h10000 : {1'b0, chunk_ff};
      fill_nx = {1'b0, cfill_ff} + 17'd1;
      wf_nx = wf_ff | req_data.sink_error;
      case (ph_ff)
         PH_OPCODE: begin
            n = 2'd1; ph_in = PH_HUNT; win_in = '0; fill_in = '0; idx_in = '0;
            if (req_data.req_type) k0 = K_DROPPED;
            else if (b == "W") begin
               n = 2'd0; ph_in = PH_NLEN; nrem_in = '0;
            end else if (b == "L" || b == "R" || b == "S" || b == "T" ||
                         b == "A" || b == "N" || b == "K") begin
               k0 = K_HANDOFF; b0 = b;
            end else begin
               k0 = K_UNSUP; b0 = b;
            end
         end
         PH_NLEN, PH_NAME, PH_PLEN: begin
            if (req_data.req_type) begin
               n = 2'd1; k0 = K_DROPPED;
               ph_in = PH_HUNT; win_in = '0; fill_in = '0; idx_in = '0;
            end else if (ph_ff == PH_NLEN) begin
               if (idx_ff == 2'd0) begin
                  nrem_in = {8'd0, b}; idx_in = 2'd1;
               end else begin
                  nrem_in = nlen; idx_in = '0;
                  if (nlen > maxn_ff) begin
                     n = 2'd1; k0 = K_DROPPED;
                     ph_in = PH_HUNT; win_in = '0; fill_in = '0;
                  end else if (nlen == 16'd0) begin
                     ph_in = PH_PLEN; prem_in = '0;
                  end else ph_in = PH_NAME;
               end
            end else if (ph_ff == PH_NAME) begin
               n = 2'd1; k0 = K_NAME; b0 = b;
               nrem_in = nrem_ff - 16'd1;
               if (nrem_in == 16'd0) begin
                  ph_in = PH_PLEN; idx_in = '0; prem_in = '0;
               end
            end else begin
               acc32 = (idx_ff == 2'd0) ? 32'd0 : prem_ff;
               acc32 = acc32 | ({24'd0, b} << {idx_ff, 3'b000});
               prem_in = acc32;
               if (idx_ff != 2'd3) idx_in = idx_ff + 2'd1;
               else begin
                  n = 2'd1; idx_in = '0;
                  if (req_data.sink_error) begin
                     k0 = K_ERR_CREATE;
                     ph_in = PH_HUNT; win_in = '0; fill_in = '0;
                  end else begin
                     k0 = K_READY; crc_in = '0; cfill_in = '0; wf_in = 1'b0;
                     exp_in = '0;
                     ph_in = (acc32 == 32'd0) ? PH_CRC : PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            if (req_data.req_type) begin
               n = 2'd1; k0 = K_ERR_IO;
               ph_in = PH_HUNT; win_in = '0; fill_in = '0; idx_in = '0;
            end else begin
               n = 2'd1; k0 = K_PAYLOAD; b0 = b;
               crc_in = crc_byte(crc_ff, b); wf_in = wf_nx; prem_in = prem_dec;
               if (fill_nx >= eff || prem_dec == 32'd0) begin
                  n = 2'd2;
                  if (wf_nx) begin
                     k1 = K_ERR_IO;
                     ph_in = PH_HUNT; win_in = '0; fill_in = '0; idx_in = '0;
                  end else begin
                     k1 = K_ACK; cfill_in = '0;
                     if (prem_dec == 32'd0) begin
                        exp_in = '0; ph_in = PH_CRC; idx_in = '0;
                     end
                  end
               end else cfill_in = fill_nx[15:0];
            end
         end
         PH_CRC: begin
            ph_in = PH_HUNT;
            if (req_data.req_type) begin
               n = 2'd1; k0 = K_ERR_CRC; win_in = '0; fill_in = '0; idx_in = '0;
            end else begin
               ph_in = PH_CRC;
               acc32 = (idx_ff == 2'd0) ? 32'd0 : exp_ff;
               acc32 = acc32 | ({24'd0, b} << {idx_ff, 3'b000});
               exp_in = acc32;
               if (idx_ff != 2'd3) idx_in = idx_ff + 2'd1;
               else begin
                  n = 2'd1; k0 = (acc32 == crc_ff) ? K_OK : K_ERR_CRC;
                  ph_in = PH_HUNT; win_in = '0; fill_in = '0; idx_in = '0;
               end
            end
         end
         default: begin
            ph_in = PH_HUNT;
            if (!req_data.req_type) begin
               win_in = {win_ff[23:0], b};
               if (fill_ff < 3'd4) fill_in = fill_ff + 3'd1;
               if (fill_in >= 3'd4) begin
                  if (win_in == MAGIC_UPL) begin
                     win_in = '0; fill_in = '0; ph_in = PH_NLEN; idx_in = '0;
                     nrem_in = '0;
                  end else if (win_in == MAGIC_CMD) begin
                     win_in = '0; fill_in = '0; ph_in = PH_OPCODE;
                  end else begin
                     n = 2'd1; k0 = K_PASS; b0 = win_in[31:24];
                     win_in = {8'd0, win_in[23:0]}; fill_in = 3'd3;
                  end
               end
            end
         end
      endcase
      pair.two    = n == 2'd2;
      pair.first  = '{kind: k0, out_byte: b0, last: n == 2'd1};
      pair.second = '{kind: k1, out_byte: 8'd0, last: 1'b1};
   end

   assign push = acc && n != 2'd0;

   ufr_out_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(pair), .room(room),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= 16'd512; maxn_ff <= 16'd255;
         win_ff <= '0; fill_ff <= '0; ph_ff <= PH_HUNT; idx_ff <= '0;
         nrem_ff <= '0; prem_ff <= '0; cfill_ff <= '0; crc_ff <= '0;
         exp_ff <= '0; wf_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == 3'd0) chunk_ff <= csr_pwdata[15:0];
            else if (csr_paddr == 3'd4) maxn_ff <= csr_pwdata[15:0];
         end
         if (acc) begin
            win_ff <= win_in; fill_ff <= fill_in; ph_ff <= ph_in; idx_ff <= idx_in;
            nrem_ff <= nrem_in; prem_ff <= prem_in; cfill_ff <= cfill_in;
            crc_ff <= crc_in; exp_ff <= exp_in; wf_ff <= wf_in;
         end
      end
   end
endmodule

/* rtl/ufr_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_out_queue
// Holds up to two result pairs and serializes them into single items.
// ----------------------------------------------------------------------------
module ufr_out_queue import ufr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_pair_type push_data,
   output logic         room,
   output logic         rsp_valid,
   output rsp_item_type rsp_data,
   input  logic         rsp_stall
);
   rsp_pair_type slot_ff [2];
   rsp_pair_type slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       half_ff, half_in;
   logic       pop, pop_pair;

   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = half_ff ? slot_ff[0].second : slot_ff[0].first;
   assign pop       = rsp_valid && !rsp_stall;
   assign pop_pair  = pop && (half_ff || !slot_ff[0].two);
   // accept only when one slot is sure to be free next cycle
   assign room      = count_ff == 2'd0 || (count_ff == 2'd1) || pop_pair;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      half_in  = half_ff;
      if (pop) half_in = !pop_pair;
      if (pop_pair) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) slot_in[0] = push_data;
         else slot_in[1] = push_data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
         half_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         half_ff  <= half_in;
      end
   end
endmodule

/* tb/upload_frame_receiver_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upload_frame_receiver_top_tb
// Drives byte and timeout transactions into the upload frame receiver. Builds
// well-formed upload frames, command frames, truncated frames and line noise.
// Predicts every result from a model of the frame parser and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module upload_frame_receiver_top_tb;
   import ufr_pkg::*;

   localparam logic [2:0]  ADDR_CHUNK_SIZE = 3'h0;
   localparam logic [2:0]  ADDR_MAX_NAME   = 3'h4;
   localparam int          CRC_LEN         = 4;
   localparam logic [63:0] OPCODE_CHARS    = "LRSTANKW";

   typedef enum logic [3:0] {
      PH_HUNT, PH_OPCODE, PH_NLEN, PH_NAME, PH_PLEN, PH_PAYLOAD, PH_CRC
   } parse_phase_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_type_t_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_item_type   rsp_data;
   logic           csr_psel = 1'b0;
   logic           csr_penable = 1'b0;
   logic           csr_pwrite = 1'b0;
   logic [2:0]     csr_paddr = '0;
   logic [31:0]    csr_pwdata = '0;
   logic [31:0]    csr_prdata;
   logic           csr_pready;

   upload_frame_receiver_top dut (.*);

   // parser state mirrored by the predictor
   logic [15:0]     chunk_size_q;
   logic [15:0]     max_name_q;
   logic [31:0]     window_q;
   int unsigned     window_fill;
   parse_phase_type phase_q;
   int unsigned     field_idx;
   logic [15:0]     name_left;
   logic [31:0]     payload_left;
   logic [16:0]     chunk_fill_q;
   logic [31:0]     payload_crc_q;
   logic [31:0]     closing_crc_q;
   logic            write_fault_q;

   req_type_t_type pending_bytes[$];
   rsp_item_type   expected_results[$];
   int             error_count = 0;
   bit             burst_on = 1'b0;
   int             burst_left = 0;
   int             stall_mode = 0;
   bit             req_taken = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return ~c;
   endfunction

   function automatic void push_result(input kind_type k, input logic [7:0] b,
                                       inout rsp_item_type res[$]);
      rsp_item_type r;
      r.kind = k;
      r.out_byte = b;
      r.last = 1'b0;
      res.push_back(r);
   endfunction

   function automatic void leave_frame();
      phase_q = PH_HUNT;
      window_q = '0;
      window_fill = 0;
      field_idx = 0;
   endfunction

   // advance the parser by one transaction and queue what it yields
   function automatic void predict_parse(input req_type_t_type t);
      rsp_item_type res[$];
      logic [7:0]   b;
      logic [16:0]  eff;
      b = t.byte_value;
      case (phase_q)
         PH_OPCODE: begin
            if (t.req_type) begin
               push_result(K_DROPPED, 8'h00, res); leave_frame();
            end else if (b == "W") begin
               phase_q = PH_NLEN; field_idx = 0; name_left = '0;
            end else if (b inside {"L", "R", "S", "T", "A", "N", "K"}) begin
               push_result(K_HANDOFF, b, res); leave_frame();
            end else begin
               push_result(K_UNSUP, b, res); leave_frame();
            end
         end
         PH_NLEN: begin
            if (t.req_type) begin
               push_result(K_DROPPED, 8'h00, res); leave_frame();
            end else if (field_idx == 0) begin
               name_left = {8'h00, b}; field_idx = 1;
            end else begin
               name_left[15:8] = b;
               if (name_left > max_name_q) begin
                  push_result(K_DROPPED, 8'h00, res); leave_frame();
               end else if (name_left == 0) begin
                  phase_q = PH_PLEN; field_idx = 0; payload_left = '0;
               end else begin
                  phase_q = PH_NAME; field_idx = 0;
               end
            end
         end
         PH_NAME: begin
            if (t.req_type) begin
               push_result(K_DROPPED, 8'h00, res); leave_frame();
            end else begin
               push_result(K_NAME, b, res);
               name_left--;
               if (name_left == 0) begin
                  phase_q = PH_PLEN; field_idx = 0; payload_left = '0;
               end
            end
         end
         PH_PLEN: begin
            if (t.req_type) begin
               push_result(K_DROPPED, 8'h00, res); leave_frame();
            end else begin
               if (field_idx == 0) payload_left = '0;
               payload_left |= {24'd0, b} << (8 * field_idx);
               if (field_idx < 3) begin
                  field_idx++;
               end else if (t.sink_error) begin
                  push_result(K_ERR_CREATE, 8'h00, res); leave_frame();
               end else begin
                  push_result(K_READY, 8'h00, res);
                  payload_crc_q = '0; chunk_fill_q = '0;
                  write_fault_q = 1'b0; closing_crc_q = '0;
                  phase_q = (payload_left == 0) ? PH_CRC : PH_PAYLOAD;
                  field_idx = 0;
               end
            end
         end
         PH_PAYLOAD: begin
            if (t.req_type) begin
               push_result(K_ERR_IO, 8'h00, res); leave_frame();
            end else begin
               push_result(K_PAYLOAD, b, res);
               payload_crc_q = crc_step(payload_crc_q, b);
               if (t.sink_error) write_fault_q = 1'b1;
               payload_left--;
               eff = (chunk_size_q == 0) ? 17'h10000 : {1'b0, chunk_size_q};
               if (chunk_fill_q + 1 >= eff || payload_left == 0) begin
                  if (write_fault_q) begin
                     push_result(K_ERR_IO, 8'h00, res); leave_frame();
                  end else begin
                     push_result(K_ACK, 8'h00, res);
                     chunk_fill_q = '0;
                     if (payload_left == 0) begin
                        closing_crc_q = '0; phase_q = PH_CRC; field_idx = 0;
                     end
                  end
               end else begin
                  chunk_fill_q = chunk_fill_q + 1;
               end
            end
         end
         PH_CRC: begin
            if (t.req_type) begin
               push_result(K_ERR_CRC, 8'h00, res); leave_frame();
            end else begin
               if (field_idx == 0) closing_crc_q = '0;
               closing_crc_q |= {24'd0, b} << (8 * field_idx);
               if (field_idx < 3) begin
                  field_idx++;
               end else begin
                  push_result(closing_crc_q == payload_crc_q ? K_OK : K_ERR_CRC,
                              8'h00, res);
                  leave_frame();
               end
            end
         end
         default: begin
            phase_q = PH_HUNT;
            if (!t.req_type) begin
               window_q = {window_q[23:0], b};
               if (window_fill < 4) window_fill++;
               if (window_fill >= 4) begin
                  if (window_q == MAGIC_UPL) begin
                     window_q = '0; window_fill = 0;
                     phase_q = PH_NLEN; field_idx = 0; name_left = '0;
                  end else if (window_q == MAGIC_CMD) begin
                     window_q = '0; window_fill = 0; phase_q = PH_OPCODE;
                  end else begin
                     push_result(K_PASS, window_q[31:24], res);
                     window_q[31:24] = 8'h00;
                     window_fill = 3;
                  end
               end
            end
         end
      endcase
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) expected_results.push_back(res[i]);
   endfunction

   // record the handshake at the rising edge and predict its results
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) predict_parse(req_data);
   end

   // sender: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (burst_left == 0) begin
            burst_on = !burst_on;
            burst_left = burst_on ? $urandom_range(1, 40) :
                         (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
         end
         if (burst_left > 0) burst_left--;
         if (burst_on && pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern that changes mode now and then
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result kind=%0d byte=%02h", rsp_data.kind, rsp_data.out_byte);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind: expected %0d, actual %0d", e.kind, rsp_data.kind);
               error_count++;
            end
            if (rsp_data.out_byte !== e.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", e.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0b, actual %0b", e.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic serr = 1'b0);
      req_type_t_type t;
      t.req_type = 1'b0;
      t.byte_value = b;
      t.sink_error = serr;
      pending_bytes.push_back(t);
   endtask

   task automatic add_timeout();
      req_type_t_type t;
      t.req_type = 1'b1;
      t.byte_value = 8'($urandom);
      t.sink_error = 1'($urandom);
      pending_bytes.push_back(t);
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) add_byte(w[8 * i +: 8]);
   endtask

   // build an upload frame; fault selects a deliberate defect
   task automatic add_upload(input bit via_cmd, input int name_len, input int pay_len,
                             input int fault);
      logic [31:0] crc;
      logic [7:0]  b;
      crc = '0;
      if (via_cmd) begin
         add_word(MAGIC_CMD); add_byte("W");
      end else begin
         add_word(MAGIC_UPL);
      end
      add_byte(name_len[7:0]); add_byte(name_len[15:8]);
      for (int i = 0; i < name_len; i++) add_byte(8'($urandom), 1'($urandom));
      if (fault == 1) begin add_timeout(); return; end
      for (int i = 0; i < 4; i++) add_byte(pay_len[8 * i +: 8], (i == 3) && (fault == 2));
      if (fault == 2) return;
      for (int i = 0; i < pay_len; i++) begin
         b = 8'($urandom);
         crc = crc_step(crc, b);
         add_byte(b, (fault == 3) && ($urandom_range(0, 15) == 0));
         if (fault == 4 && i == pay_len / 2) begin add_timeout(); return; end
      end
      if (fault == 5) crc ^= 32'h1 << $urandom_range(0, 31);
      for (int i = 0; i < 3; i++) add_byte(crc[8 * i +: 8]);
      if (fault == 6) begin add_timeout(); return; end
      add_byte(crc[31:24]);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_CHUNK_SIZE) chunk_size_q = value[15:0];
      else max_name_q = value[15:0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int sizes[4];
      int pick;
      chunk_size_q = 16'd512; max_name_q = 16'd255;
      window_q = '0; window_fill = 0; phase_q = PH_HUNT; field_idx = 0;
      name_left = '0; payload_left = '0; chunk_fill_q = '0;
      payload_crc_q = '0; closing_crc_q = '0; write_fault_q = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a list of special cases, each once
      csr_write(ADDR_CHUNK_SIZE, 32'd4);
      csr_write(ADDR_MAX_NAME, 32'd8);
      add_byte(8'h00); add_byte(8'hFF); add_timeout(); add_byte(8'h45);
      add_upload(1'b0, 2, 9, 0);
      add_upload(1'b1, 0, 0, 0);
      add_word(MAGIC_CMD); add_byte("L");
      add_word(MAGIC_CMD); add_byte(8'hFF);
      add_word(MAGIC_CMD); add_timeout();
      add_word(MAGIC_UPL); add_byte(8'd9); add_byte(8'd0);
      add_word(MAGIC_UPL); add_byte(8'd1); add_byte(8'hFF);
      add_upload(1'b0, 1, 3, 2);
      add_upload(1'b0, 0, 6, 3);
      add_upload(1'b0, 0, 6, 5);
      add_upload(1'b0, 0, 2, 6);
      drain();

      csr_write(ADDR_CHUNK_SIZE, 32'd0);
      csr_write(ADDR_MAX_NAME, 32'd0);
      add_upload(1'b0, 0, 5, 0);
      add_upload(1'b0, 0, 5, 4);
      add_word(MAGIC_UPL); add_byte(8'd1); add_byte(8'd0);
      drain();

      // random phases across several register settings
      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin csr_write(ADDR_CHUNK_SIZE, 32'd1); csr_write(ADDR_MAX_NAME, 32'd4); end
            1: begin csr_write(ADDR_CHUNK_SIZE, 32'd65535);
                     csr_write(ADDR_MAX_NAME, 32'd65535); end
            2: begin csr_write(ADDR_CHUNK_SIZE, 32'd3); csr_write(ADDR_MAX_NAME, 32'd2); end
            default: begin csr_write(ADDR_CHUNK_SIZE, $urandom_range(1, 12));
                           csr_write(ADDR_MAX_NAME, $urandom_range(0, 6)); end
         endcase
         while (pending_bytes.size() < 120) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               add_upload($urandom_range(0, 1), $urandom_range(0, 6),
                          $urandom_range(0, 14), ($urandom_range(0, 2) == 0) ?
                          $urandom_range(1, 6) : 0);
            end else if (pick < 15) begin
               add_word(MAGIC_CMD);
               add_byte(($urandom_range(0, 1) == 0) ?
                        OPCODE_CHARS[8 * $urandom_range(0, 7) +: 8] : 8'($urandom));
            end else if (pick < 16) begin
               add_timeout();
            end else begin
               repeat ($urandom_range(1, 6)) add_byte(8'($urandom), 1'($urandom));
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
